[hw/rtl/tga_pixel_unpacker_top_macros.svh]
// Assertion macros for the targa pixel unpacker.
// Needs nothing else; define NO_ASSERTIONS to leave all checks out.
`ifndef TGA_PIXEL_UNPACKER_TOP_MACROS_SVH
`define TGA_PIXEL_UNPACKER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TGAPU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tga_pixel_unpacker: assertion failed");
`define TGAPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tga_pixel_unpacker: assertion failed");
`else
`define TGAPU_ASSERT(label, clk, rst_n, prop)
`define TGAPU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/tgapu_pkg.sv]
// Shared types and constants of the targa pixel unpacker.
// Has no dependencies; used by tga_pixel_unpacker_top.
package tgapu_pkg;

    typedef logic [1:0] t_cfg_index;
    typedef logic [1:0] t_pixel_format;

    localparam t_cfg_index CFG_RLE_MODE     = 2'd0;
    localparam t_cfg_index CFG_PIXEL_FORMAT = 2'd1;
    localparam t_cfg_index CFG_IMAGE_WIDTH  = 2'd2;
    localparam t_cfg_index CFG_IMAGE_HEIGHT = 2'd3;

    localparam t_pixel_format FMT_RGB555 = 2'd0;
    localparam t_pixel_format FMT_BGR24  = 2'd1;
    localparam t_pixel_format FMT_BGRA32 = 2'd2;

    localparam int DIM_BITS = 15;

    // Packet headers at or above this value announce a run.
    localparam logic [7:0] RLE_RUN_FLAG = 8'd128;
    localparam logic [7:0] RLE_RUN_BIAS = 8'd127;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       end_of_image;
    } t_result;

endpackage

[hw/rtl/tga_pixel_unpacker_top.sv]
// Targa pixel-data unpacker: raw BGR(A)/5-5-5 and RLE BGR(A) bytes to RGB(A) pixels.
// Depends on tgapu_pkg and tga_pixel_unpacker_top_macros.svh.
//
// Channel   Signals                                  Direction
// in        i_in_valid, o_in_ready, i_data_byte      byte request in
// out       o_out_valid, i_out_ready, o_red..o_end_of_image   pixel request out
// cfg       i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data register write in
//
// One byte is taken per clock unless the input side stalls. A byte is captured in the
// input register and then decoded into the result register, which presents the pixel.
// The saturated image size is registered on the same edge as a width or height write.
// A stalled output holds the result register and the input register; the input side
// stalls only when both are full.
// Synchronous reset clears the parser state and result register, not the input byte.
`include "tga_pixel_unpacker_top_macros.svh"

module tga_pixel_unpacker_top #(
    parameter int COUNT_BITS = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [7:0]  o_repeat_count,
    output logic        o_end_of_image,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam int          EXT_BITS = 33;
    localparam logic [32:0] COUNT_LIMIT = (33'd1 << COUNT_BITS) - 33'd1;

    // Configuration registers.
    logic        r_rle_mode;
    logic [1:0]  r_pixel_format;
    logic [14:0] r_image_width;
    logic [14:0] r_image_height;

    // Image size, saturated and never zero.
    logic [COUNT_BITS-1:0] r_total;
    logic [14:0]           w_width_next;
    logic [14:0]           w_height_next;
    logic [29:0]           w_product;
    logic [32:0]           w_total_ext;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Parser state.
    logic                  r_awaiting_header, n_awaiting_header;
    logic [7:0]            r_packet_remaining, n_packet_remaining;
    logic                  r_packet_is_run, n_packet_is_run;
    logic [1:0]            r_byte_position, n_byte_position;
    logic [7:0]            r_pixel_bytes [4];
    logic [7:0]            n_pixel_bytes [4];
    logic [COUNT_BITS-1:0] r_pixels_done, n_pixels_done;

    // Result register.
    logic                  r_out_valid;
    tgapu_pkg::t_result    r_out;
    tgapu_pkg::t_result    w_result;
    logic                  w_result_valid;

    logic                  w_advance;
    logic                  w_swallow;
    logic [2:0]            w_bytes_per_pixel;
    logic [15:0]           w_word;
    logic [COUNT_BITS-1:0] w_left;
    logic [7:0]            w_rep_raw;
    logic [7:0]            w_rep;
    logic                  w_eoi;
    logic                  w_eoi_taken;
    logic                  w_restarted;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;
    assign w_swallow   = r_rle_mode && (r_pixel_format == tgapu_pkg::FMT_RGB555);

    // The size is taken from the values the registers hold after this edge.
    always_comb begin
        w_width_next  = r_image_width;
        w_height_next = r_image_height;
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == tgapu_pkg::CFG_IMAGE_WIDTH) begin
                w_width_next = i_cfg_data;
            end
            if (i_cfg_index == tgapu_pkg::CFG_IMAGE_HEIGHT) begin
                w_height_next = i_cfg_data;
            end
        end
        w_product   = {15'd0, w_width_next} * {15'd0, w_height_next};
        w_total_ext = EXT_BITS'(w_product);
        if (w_total_ext > COUNT_LIMIT) begin
            w_total_ext = COUNT_LIMIT;
        end
        if (w_total_ext == '0) begin
            w_total_ext = 33'd1;
        end
    end

    always_comb begin
        unique case (r_pixel_format)
            tgapu_pkg::FMT_RGB555: w_bytes_per_pixel = 3'd2;
            tgapu_pkg::FMT_BGR24:  w_bytes_per_pixel = 3'd3;
            default:               w_bytes_per_pixel = 3'd4;
        endcase
    end

    // Remaining pixels of the image and the clipped repeat count.
    always_comb begin
        w_left = (r_pixels_done < r_total) ? (r_total - r_pixels_done)
                                           : COUNT_BITS'(1);
        w_rep_raw = (r_rle_mode && r_packet_is_run) ? r_packet_remaining : 8'd1;
        if (w_rep_raw == 8'd0) begin
            w_rep_raw = 8'd1;
        end
        w_rep = (COUNT_BITS'(w_rep_raw) > w_left) ? w_left[7:0] : w_rep_raw;
        w_eoi = (COUNT_BITS'(w_rep) == w_left);
    end

    always_comb begin
        n_awaiting_header  = r_awaiting_header;
        n_packet_remaining = r_packet_remaining;
        n_packet_is_run    = r_packet_is_run;
        n_byte_position    = r_byte_position;
        n_pixels_done      = r_pixels_done;
        n_pixel_bytes      = r_pixel_bytes;
        w_result_valid     = 1'b0;
        w_result           = '0;
        w_word             = '0;

        if (w_swallow) begin
            // Run-length coding of 5-5-5 pixels is not handled; bytes are dropped.
        end else if (r_rle_mode && r_awaiting_header) begin
            if (r_in_byte < tgapu_pkg::RLE_RUN_FLAG) begin
                n_packet_is_run    = 1'b0;
                n_packet_remaining = r_in_byte + 8'd1;
            end else begin
                n_packet_is_run    = 1'b1;
                n_packet_remaining = r_in_byte - tgapu_pkg::RLE_RUN_BIAS;
            end
            n_awaiting_header = 1'b0;
            n_byte_position   = 2'd0;
        end else begin
            n_pixel_bytes[r_byte_position] = r_in_byte;
            if (({1'b0, r_byte_position} + 3'd1) < w_bytes_per_pixel) begin
                n_byte_position = r_byte_position + 2'd1;
            end else begin
                n_byte_position = 2'd0;
                w_result_valid  = 1'b1;
                w_word          = {n_pixel_bytes[1], n_pixel_bytes[0]};
                if (r_pixel_format == tgapu_pkg::FMT_RGB555) begin
                    w_result.blue  = {w_word[4:0], 3'd0};
                    w_result.green = {w_word[9:5], 3'd0};
                    w_result.red   = {w_word[14:10], 3'd0};
                    w_result.alpha = 8'd0;
                end else begin
                    w_result.red   = n_pixel_bytes[2];
                    w_result.green = n_pixel_bytes[1];
                    w_result.blue  = n_pixel_bytes[0];
                    w_result.alpha = (r_pixel_format == tgapu_pkg::FMT_BGR24)
                                     ? 8'd0 : n_pixel_bytes[3];
                end
                w_result.repeat_count = w_rep;
                w_result.end_of_image = w_eoi;
                n_pixels_done = r_pixels_done + COUNT_BITS'(w_rep);

                if (r_rle_mode) begin
                    if (r_packet_is_run || r_packet_remaining <= 8'd1) begin
                        n_packet_remaining = 8'd0;
                    end else begin
                        n_packet_remaining = r_packet_remaining - 8'd1;
                    end
                    if (n_packet_remaining == 8'd0) begin
                        n_awaiting_header = 1'b1;
                    end
                end

                // The pixel that completes the image restarts the parser.
                if (w_eoi) begin
                    n_pixels_done      = '0;
                    n_awaiting_header  = 1'b1;
                    n_packet_remaining = 8'd0;
                    n_packet_is_run    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_mode     <= 1'b0;
            r_pixel_format <= tgapu_pkg::FMT_BGR24;
            r_image_width  <= 15'd1;
            r_image_height <= 15'd1;
            r_total        <= COUNT_BITS'(1);
        end else begin
            r_total <= w_total_ext[COUNT_BITS-1:0];
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    tgapu_pkg::CFG_RLE_MODE:     r_rle_mode     <= i_cfg_data[0];
                    tgapu_pkg::CFG_PIXEL_FORMAT: r_pixel_format <= i_cfg_data[1:0];
                    tgapu_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    tgapu_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_awaiting_header  <= 1'b1;
            r_packet_remaining <= 8'd0;
            r_packet_is_run    <= 1'b0;
            r_byte_position    <= 2'd0;
            r_pixels_done      <= '0;
            r_pixel_bytes      <= '{default: 8'd0};
            r_out              <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid        <= w_result_valid;
                r_awaiting_header  <= n_awaiting_header;
                r_packet_remaining <= n_packet_remaining;
                r_packet_is_run    <= n_packet_is_run;
                r_byte_position    <= n_byte_position;
                r_pixels_done      <= n_pixels_done;
                r_pixel_bytes      <= n_pixel_bytes;
                if (w_result_valid) begin
                    r_out <= w_result;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red          = r_out.red;
    assign o_green        = r_out.green;
    assign o_blue         = r_out.blue;
    assign o_alpha        = r_out.alpha;
    assign o_repeat_count = r_out.repeat_count;
    assign o_end_of_image = r_out.end_of_image;

    assign w_eoi_taken = w_advance && w_result_valid && w_eoi;
    assign w_restarted = (r_pixels_done == '0) && r_awaiting_header;

    // A result never carries a zero repeat count.
    `TGAPU_ASSERT(a_rep_nonzero, i_clk, i_rst_n, !o_out_valid || (o_repeat_count != 8'd0))
    // The pixel that ends the image resets the count and rearms the header parser.
    `TGAPU_ASSERT_NEXT(a_eoi_restart, i_clk, i_rst_n, w_eoi_taken, w_restarted)
    // Dropped bytes leave no result behind.
    `TGAPU_ASSERT_NEXT(a_swallow_quiet, i_clk, i_rst_n, w_advance && w_swallow, !r_out_valid)
    // A held byte stays in the input register until it is decoded.
    `TGAPU_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, !o_in_ready, r_in_valid && $stable(r_in_byte))

endmodule

[tb/tga_pixel_unpacker_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for tga_pixel_unpacker_top: directed rows, then random register
// phases with raw and run-length byte streams, checked against a cycle-free pixel predictor.
// Depends on tgapu_pkg and the tga_pixel_unpacker_top RTL.
module tga_pixel_unpacker_top_test;

    localparam int COUNT_BITS = 30;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_BYTES = 1150;
    // The fourth format code has no name in the package; the block treats it as BGRA.
    localparam tgapu_pkg::t_pixel_format FMT_BGRA32_ALT = 2'd3;

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        tgapu_pkg::t_cfg_index reg_idx;
        logic [14:0]           reg_val;
        logic [7:0]            data;
        bit                    typed;
        tgapu_pkg::t_result    want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic [7:0]  o_repeat_count;
    logic        o_end_of_image;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [14:0] i_cfg_data = 15'd0;

    tga_pixel_unpacker_top u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor copy of the registers and of the parser state.
    bit                       cfg_rle = 1'b0;
    tgapu_pkg::t_pixel_format cfg_fmt = tgapu_pkg::FMT_BGR24;
    logic [14:0]              cfg_width = 15'd1;
    logic [14:0]              cfg_height = 15'd1;
    bit                       hdr_wait = 1'b1;
    logic [7:0]               pkt_left = 8'd0;
    bit                       pkt_run = 1'b0;
    int                       byte_idx = 0;
    logic [7:0]               pix_buf [4] = '{default: 8'h00};
    logic [COUNT_BITS-1:0]    pix_count = '0;

    tgapu_pkg::t_result pixel_queue [$];
    t_stim_row          script [$];
    int                 mismatches = 0;
    int                 pixels_checked = 0;
    int                 bytes_sent = 0;
    int                 phases = 0;
    bit                 tx_burst = 1'b0;
    bit                 rx_burst = 1'b0;
    bit                 reg_write_open = 1'b0;

    function automatic void apply_reg(input tgapu_pkg::t_cfg_index idx,
                                      input logic [14:0] val);
        case (idx)
            tgapu_pkg::CFG_RLE_MODE:     cfg_rle = val[0];
            tgapu_pkg::CFG_PIXEL_FORMAT: cfg_fmt = val[1:0];
            tgapu_pkg::CFG_IMAGE_WIDTH:  cfg_width = val;
            tgapu_pkg::CFG_IMAGE_HEIGHT: cfg_height = val;
            default: ;
        endcase
    endfunction

    // Feeds one byte through the parser and returns the pixel it completes, if any.
    function automatic void unpack_byte(input logic [7:0] b, output bit got,
                                        output tgapu_pkg::t_result px);
        int bpp;
        longint unsigned total, left, rep;
        logic [15:0] word;
        got = 1'b0;
        px = '0;
        bpp = (cfg_fmt == tgapu_pkg::FMT_RGB555) ? 2 :
              (cfg_fmt == tgapu_pkg::FMT_BGR24) ? 3 : 4;
        // Run-length packets of 5-5-5 pixels are not supported and leave no trace.
        if (cfg_rle && cfg_fmt == tgapu_pkg::FMT_RGB555) return;
        if (cfg_rle && hdr_wait) begin
            pkt_run = (b >= tgapu_pkg::RLE_RUN_FLAG);
            pkt_left = pkt_run ? 8'(b - tgapu_pkg::RLE_RUN_BIAS) : 8'(b + 8'd1);
            hdr_wait = 1'b0;
            byte_idx = 0;
            return;
        end
        pix_buf[byte_idx] = b;
        if (byte_idx + 1 < bpp) begin
            byte_idx++;
            return;
        end
        byte_idx = 0;
        if (cfg_fmt == tgapu_pkg::FMT_RGB555) begin
            word = {pix_buf[1], pix_buf[0]};
            px.blue = {word[4:0], 3'b000};
            px.green = {word[9:5], 3'b000};
            px.red = {word[14:10], 3'b000};
            px.alpha = 8'h00;
        end else begin
            px.red = pix_buf[2];
            px.green = pix_buf[1];
            px.blue = pix_buf[0];
            px.alpha = (cfg_fmt == tgapu_pkg::FMT_BGR24) ? 8'h00 : pix_buf[3];
        end
        total = 64'(cfg_width) * 64'(cfg_height);
        if (total > COUNT_MAX) total = COUNT_MAX;
        if (total == 0) total = 1;
        left = (64'(pix_count) < total) ? total - 64'(pix_count) : 1;
        rep = (cfg_rle && pkt_run) ? 64'(pkt_left) : 1;
        if (rep == 0) rep = 1;
        if (rep > left) rep = left;
        pix_count = COUNT_BITS'(64'(pix_count) + rep);
        if (cfg_rle) begin
            if (pkt_run || pkt_left <= 8'd1) pkt_left = 8'd0;
            else pkt_left--;
            if (pkt_left == 8'd0) hdr_wait = 1'b1;
        end
        px.repeat_count = rep[7:0];
        px.end_of_image = (rep == left);
        // Completing the image restarts the count and the packet parser.
        if (px.end_of_image) begin
            pix_count = '0;
            hdr_wait = 1'b1;
            pkt_left = 8'd0;
            pkt_run = 1'b0;
        end
        got = 1'b1;
    endfunction

    function automatic logic [14:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 15'd0;
            1: return 15'd32767;
            2: return 15'($urandom_range(0, 32767));
            default: return 15'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b, input bit typed,
                            input tgapu_pkg::t_result want);
        t_stim_row row;
        row.kind = ROW_BYTE;
        row.reg_idx = tgapu_pkg::CFG_RLE_MODE;
        row.reg_val = '0;
        row.data = b;
        row.typed = typed;
        row.want = want;
        script.insert(script.size(), row);
    endtask

    task automatic add_reg(input tgapu_pkg::t_cfg_index idx, input logic [14:0] val);
        t_stim_row row;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.data = 8'h00;
        row.typed = 1'b0;
        row.want = '0;
        script.insert(script.size(), row);
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
    endtask

    // Lowers the byte request and lets the pipeline empty before registers change.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input tgapu_pkg::t_cfg_index idx, input logic [14:0] val);
        if (!reg_write_open) wait_idle();
        reg_write_open = 1'b1;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input tgapu_pkg::t_result want);
        int gap;
        bit got;
        tgapu_pkg::t_result px;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (reg_write_open) begin
            i_cfg_valid <= 1'b0;
            reg_write_open = 1'b0;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        unpack_byte(b, got, px);
        if (typed) pixel_queue.insert(pixel_queue.size(), want);
        else if (got) pixel_queue.insert(pixel_queue.size(), px);
        @(negedge i_clk);
    endtask

    initial begin : byte_source
        int random_bytes;
        int sel;
        int n;
        bit swallow;
        logic [7:0] b;
        random_bytes = 0;

        // Reset settings first: 24-bit raw, one-pixel image.
        add_byte(8'h00, 1'b0, '0);
        add_byte(8'hFF, 1'b0, '0);
        add_byte(8'h80, 1'b1, '{8'h80, 8'hFF, 8'h00, 8'h00, 8'd1, 1'b1});
        add_reg(tgapu_pkg::CFG_PIXEL_FORMAT, 15'(tgapu_pkg::FMT_BGRA32));
        add_reg(tgapu_pkg::CFG_IMAGE_WIDTH, 15'd2);
        repeat (3) add_byte(8'hFF, 1'b0, '0);
        add_byte(8'hFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 1'b0});
        repeat (3) add_byte(8'h00, 1'b0, '0);
        add_byte(8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1});
        add_reg(tgapu_pkg::CFG_PIXEL_FORMAT, 15'(tgapu_pkg::FMT_RGB555));
        add_byte(8'hFF, 1'b0, '0);
        add_byte(8'h7F, 1'b1, '{8'hF8, 8'hF8, 8'hF8, 8'h00, 8'd1, 1'b0});
        add_byte(8'h00, 1'b0, '0);
        add_byte(8'h80, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1});
        // Run-length mode with 5-5-5 pixels swallows everything.
        add_reg(tgapu_pkg::CFG_RLE_MODE, 15'd1);
        add_byte(8'h81, 1'b0, '0);
        add_byte(8'h3C, 1'b0, '0);
        add_reg(tgapu_pkg::CFG_PIXEL_FORMAT, 15'(tgapu_pkg::FMT_BGR24));
        add_reg(tgapu_pkg::CFG_IMAGE_WIDTH, 15'd32767);
        add_reg(tgapu_pkg::CFG_IMAGE_HEIGHT, 15'd32767);
        add_byte(8'hFF, 1'b0, '0);
        add_byte(8'h11, 1'b0, '0);
        add_byte(8'h22, 1'b0, '0);
        add_byte(8'h33, 1'b1, '{8'h33, 8'h22, 8'h11, 8'h00, 8'd128, 1'b0});
        // Zero width shrinks the image below the pixels already counted.
        add_reg(tgapu_pkg::CFG_IMAGE_WIDTH, 15'd0);
        add_byte(8'h00, 1'b0, '0);
        add_byte(8'h0A, 1'b0, '0);
        add_byte(8'h0B, 1'b0, '0);
        add_byte(8'h0C, 1'b0, '0);
        add_reg(tgapu_pkg::CFG_PIXEL_FORMAT, 15'(FMT_BGRA32_ALT));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < script.size(); i++) begin
            if (script[i].kind == ROW_REG)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_byte(script[i].data, script[i].typed, script[i].want);
        end

        while (random_bytes < RANDOM_BYTES) begin
            phases++;
            if ($urandom_range(0, 1))
                write_reg(tgapu_pkg::CFG_RLE_MODE, 15'($urandom_range(0, 32767)));
            if ($urandom_range(0, 1))
                write_reg(tgapu_pkg::CFG_PIXEL_FORMAT, 15'($urandom_range(0, 32767)));
            if ($urandom_range(0, 1)) write_reg(tgapu_pkg::CFG_IMAGE_WIDTH, pick_dim());
            if ($urandom_range(0, 1)) write_reg(tgapu_pkg::CFG_IMAGE_HEIGHT, pick_dim());
            tx_burst = ($urandom_range(0, 3) == 0);
            swallow = cfg_rle && cfg_fmt == tgapu_pkg::FMT_RGB555;
            n = swallow ? 3 : $urandom_range(8, 48);
            repeat (n) begin
                if (cfg_rle && hdr_wait && !swallow) begin
                    // Mostly short packets so that images finish inside a phase.
                    sel = $urandom_range(0, 9);
                    if (sel < 4) b = 8'($urandom_range(0, 3));
                    else if (sel < 8) b = 8'(tgapu_pkg::RLE_RUN_FLAG + $urandom_range(0, 7));
                    else if (sel == 8) b = $urandom_range(0, 1) ? 8'h7F : 8'hFF;
                    else b = 8'($urandom_range(0, 255));
                end else if ($urandom_range(0, 7) == 0) begin
                    b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                send_byte(b, 1'b0, '0);
                if (!swallow) random_bytes++;
            end
        end

        wait_idle();
        repeat (3 * DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes over %0d random register phases and compared %0d pixels.",
                 bytes_sent, phases, pixels_checked);
        $display("Mismatches counted: %0d.", mismatches);
        if (mismatches == 0 && pixel_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : pixel_sink
        int stall;
        tgapu_pkg::t_result got;
        tgapu_pkg::t_result want;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (pixels_checked % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got = '{o_red, o_green, o_blue, o_alpha, o_repeat_count, o_end_of_image};
            pixels_checked++;
            if (pixel_queue.size() == 0) begin
                note_mismatch("unexpected pixel, red", 0, got.red);
            end else begin
                want = pixel_queue.pop_front();
                if (got.red !== want.red) note_mismatch("red", want.red, got.red);
                if (got.green !== want.green) note_mismatch("green", want.green, got.green);
                if (got.blue !== want.blue) note_mismatch("blue", want.blue, got.blue);
                if (got.alpha !== want.alpha) note_mismatch("alpha", want.alpha, got.alpha);
                if (got.repeat_count !== want.repeat_count)
                    note_mismatch("repeat_count", want.repeat_count, got.repeat_count);
                if (got.end_of_image !== want.end_of_image)
                    note_mismatch("end_of_image", want.end_of_image, got.end_of_image);
            end
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        #1000000;
        $display("Timed out with %0d pixels outstanding.", pixel_queue.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
